>>> rtl/detection_point_accumulator_core_defines.svh
// assertion macros shared by the rtl
`ifndef DETECTION_POINT_ACCUMULATOR_CORE_DEFINES_SVH
`define DETECTION_POINT_ACCUMULATOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DPA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define DPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/dpa_pkg.sv
`default_nettype none

package dpa_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int COORD_BITS  = 12;
   localparam int COUNT_BITS  = 16;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int FILL_BITS   = $clog2(TABLE_DEPTH + 1);
   localparam int WORD_BITS   = 2 * COORD_BITS + COUNT_BITS;

   // fixed field widths of the channels
   localparam int AREA_BITS      = 21;
   localparam int BOUND_BITS     = 20;
   localparam int THRESH_BITS    = 16;
   localparam int ENTRY_IDX_BITS = 6;
   localparam int HIT_BITS       = 16;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AREA_LOW    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AREA_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPORT_THR  = 2'd2;

   // register reset values
   localparam logic [BOUND_BITS-1:0]  AREA_LOW_RESET   = '0;
   localparam logic [BOUND_BITS-1:0]  AREA_HIGH_RESET  = '1;
   localparam logic [THRESH_BITS-1:0] REPORT_THR_RESET = THRESH_BITS'(5);

   typedef struct packed {
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic [AREA_BITS-1:0]  area_half;
   } req_type;

   typedef struct packed {
      logic                      accepted;
      logic                      matched;
      logic [ENTRY_IDX_BITS-1:0] entry_index;
      logic [HIT_BITS-1:0]       hit_total;
      logic                      reported;
      logic                      dropped_full;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/detection_point_accumulator_core.sv
// Detection point accumulator. Each request carries one blob (position and area in
// half pixels). Blobs whose area lies strictly between twice area_low and twice
// area_high are looked up in a 64-entry point table held in one synchronous RAM,
// scanned one entry per cycle in insertion order: the first entry within one pixel
// in x and y gets its hit count bumped (saturating), otherwise the blob is appended,
// or dropped when the table is full. One response per request. A request that passes
// the area filter holds the block until its scan ends at the match, the append or
// the drop; a rejected request skips the scan. The response sits in an output
// register, so the next request is taken while it waits; a finished request only
// waits longer while the previous response is still stalled in that register. The
// table is empty after reset, no clearing pass.
`default_nettype none
`include "detection_point_accumulator_core_defines.svh"

module detection_point_accumulator_core (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  dpa_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output dpa_pkg::rsp_type                      rsp_data,
   input  wire                                   csr_write_en,
   input  wire  [dpa_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire  [dpa_pkg::BOUND_BITS-1:0]        csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [dpa_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

   // configuration registers
   logic [dpa_pkg::BOUND_BITS-1:0]  area_low_ff;
   logic [dpa_pkg::BOUND_BITS-1:0]  area_high_ff;
   logic [dpa_pkg::THRESH_BITS-1:0] report_thr_ff;

   // control and payload registers
   logic [1:0]                     state_ff, state_in;
   logic [dpa_pkg::FILL_BITS-1:0]  fill_ff, fill_in;
   logic [dpa_pkg::IDX_BITS-1:0]   cmp_idx_ff, cmp_idx_in;
   dpa_pkg::req_type               req_ff, req_in;
   dpa_pkg::rsp_type               res_ff, res_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   dpa_pkg::rsp_type               rsp_ff, rsp_in;

   // point table ram: {x, y, hits}
   logic [dpa_pkg::WORD_BITS-1:0]  table_mem [dpa_pkg::TABLE_DEPTH];
   logic [dpa_pkg::WORD_BITS-1:0]  rd_data_ff;
   logic [dpa_pkg::IDX_BITS-1:0]   rd_addr;
   logic                           wr_en;
   logic [dpa_pkg::IDX_BITS-1:0]   wr_addr;
   logic [dpa_pkg::WORD_BITS-1:0]  wr_data;

   // scan datapath
   logic                           req_take;
   logic                           area_ok;
   logic [dpa_pkg::COORD_BITS-1:0] ent_x;
   logic [dpa_pkg::COORD_BITS-1:0] ent_y;
   logic [dpa_pkg::COUNT_BITS-1:0] ent_hits;
   logic [dpa_pkg::COORD_BITS:0]   diff_x;
   logic [dpa_pkg::COORD_BITS:0]   diff_y;
   logic                           near_x;
   logic                           near_y;
   logic                           ent_valid;
   logic                           hit;
   logic                           last;
   logic                           full;
   logic [dpa_pkg::COUNT_BITS-1:0] new_hits;
   logic                           out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // area filter at half-pixel resolution
   assign area_ok = (req_data.area_half > {area_low_ff, 1'b0}) &&
                    (req_data.area_half < {area_high_ff, 1'b0});

   // entry under test
   assign {ent_x, ent_y, ent_hits} = rd_data_ff;
   assign diff_x = {1'b0, ent_x} - {1'b0, req_ff.pos_x};
   assign diff_y = {1'b0, ent_y} - {1'b0, req_ff.pos_y};
   assign near_x = (diff_x == '0) || (diff_x == (dpa_pkg::COORD_BITS+1)'(1)) ||
                   (diff_x == '1);
   assign near_y = (diff_y == '0) || (diff_y == (dpa_pkg::COORD_BITS+1)'(1)) ||
                   (diff_y == '1);
   assign ent_valid = (dpa_pkg::FILL_BITS'(cmp_idx_ff) < fill_ff);
   assign hit       = ent_valid && near_x && near_y;
   assign last      = (dpa_pkg::FILL_BITS'(cmp_idx_ff) + dpa_pkg::FILL_BITS'(1)) >= fill_ff;
   assign full      = (fill_ff == dpa_pkg::FILL_BITS'(dpa_pkg::TABLE_DEPTH));
   assign new_hits  = (ent_hits < COUNT_MAX) ? ent_hits + dpa_pkg::COUNT_BITS'(1) : ent_hits;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      cmp_idx_in   = cmp_idx_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_addr      = cmp_idx_ff;
      wr_en        = 1'b0;
      wr_addr      = cmp_idx_ff;
      wr_data      = {ent_x, ent_y, new_hits};

      // output register drains independently
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               req_in     = req_data;
               res_in     = '0;
               cmp_idx_in = '0;
               rd_addr    = '0;
               state_in   = area_ok ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            rd_addr    = cmp_idx_ff + dpa_pkg::IDX_BITS'(1);
            cmp_idx_in = cmp_idx_ff + dpa_pkg::IDX_BITS'(1);
            res_in.accepted = 1'b1;
            priority if (hit) begin
               // bump the matching entry
               wr_en                 = 1'b1;
               res_in.matched        = 1'b1;
               res_in.entry_index    = dpa_pkg::ENTRY_IDX_BITS'(cmp_idx_ff);
               res_in.hit_total      = dpa_pkg::HIT_BITS'(new_hits);
               res_in.reported       = (32'(new_hits) > 32'(report_thr_ff));
               state_in              = ST_DONE;
            end else if (last && full) begin
               res_in.dropped_full   = 1'b1;
               state_in              = ST_DONE;
            end else if (last) begin
               // append a new point with one hit
               wr_en                 = 1'b1;
               wr_addr               = dpa_pkg::IDX_BITS'(fill_ff);
               wr_data               = {req_ff.pos_x, req_ff.pos_y,
                                        dpa_pkg::COUNT_BITS'(1)};
               fill_in               = fill_ff + dpa_pkg::FILL_BITS'(1);
               res_in.entry_index    = dpa_pkg::ENTRY_IDX_BITS'(fill_ff);
               res_in.hit_total      = dpa_pkg::HIT_BITS'(1);
               res_in.reported       = (32'(1) > 32'(report_thr_ff));
               state_in              = ST_DONE;
            end else begin
               state_in              = ST_SCAN;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmp_idx_ff <= cmp_idx_in;
      req_ff     <= req_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         area_low_ff   <= dpa_pkg::AREA_LOW_RESET;
         area_high_ff  <= dpa_pkg::AREA_HIGH_RESET;
         report_thr_ff <= dpa_pkg::REPORT_THR_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            dpa_pkg::CSR_AREA_LOW:   area_low_ff   <= csr_wdata;
            dpa_pkg::CSR_AREA_HIGH:  area_high_ff  <= csr_wdata;
            dpa_pkg::CSR_REPORT_THR: report_thr_ff <= dpa_pkg::THRESH_BITS'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // point table ram, one read and one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   // checks
   `DPA_ASSERT_SAME(a_drop_only_full, clock, reset, rsp_valid_ff && rsp_ff.dropped_full, fill_ff == dpa_pkg::FILL_BITS'(dpa_pkg::TABLE_DEPTH), "drop reported while table not full")
   `DPA_ASSERT_SAME(a_match_consistent, clock, reset, rsp_valid_ff && rsp_ff.matched, rsp_ff.accepted && !rsp_ff.dropped_full, "match flagged on rejected or dropped blob")
   `DPA_ASSERT_NEXT(a_write_ends_scan, clock, reset, wr_en, state_ff == ST_DONE, "table write did not end the scan")

endmodule

`default_nettype wire
